@@ rtl/isms_pkg.sv @@
// Shared types, sizes and command codes of the interval set merge table.
package isms_pkg;

    localparam int MAX_SPANS = 64;
    localparam int ADDR_W    = 48;
    localparam int IDX_W     = $clog2(MAX_SPANS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int RAM_AW    = IDX_W + 1;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_QUERY  = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        t_addr lo;
        t_addr hi;
    } t_span;

    // Decision taken for one stored entry during a scan.
    typedef struct packed {
        logic  hit;
        logic  w0_v;
        t_span w0;
        logic  w1_v;
        t_span w1;
        t_span cur;
        logic  placed;
        logic  merged;
        logic  split;
    } t_step;

endpackage

@@ rtl/isms_ifs.sv @@
// Command and result channel interfaces of the interval set merge table.
interface isms_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 command;
    logic [isms_pkg::ADDR_W-1:0] span_low;
    logic [isms_pkg::ADDR_W-1:0] span_high;
    logic [5:0]                 entry_index;

    modport source (output valid, command, span_low, span_high, entry_index, input ready);
    modport sink   (input valid, command, span_low, span_high, entry_index, output ready);
endinterface

interface isms_res_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic                       overlaps;
    logic [6:0]                 span_count;
    logic                       entry_valid;
    logic [isms_pkg::ADDR_W-1:0] entry_low;
    logic [isms_pkg::ADDR_W-1:0] entry_high;

    modport source (output valid, status, overlaps, span_count, entry_valid, entry_low,
                    entry_high, input ready);
    modport sink   (input valid, status, overlaps, span_count, entry_valid, entry_low,
                    entry_high, output ready);
endinterface

@@ rtl/isms_span_ram.sv @@
// Two-bank span memory: one write port, one read port with registered data.
module isms_span_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [isms_pkg::RAM_AW-1:0] i_waddr,
    input  isms_pkg::t_span             i_wdata,
    input  logic [isms_pkg::RAM_AW-1:0] i_raddr,
    output isms_pkg::t_span             o_rdata
);
    import isms_pkg::*;

    t_span r_mem [2**RAM_AW];
    t_span r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/isms_merge_unit.sv @@
// Per-entry decision of the insert, remove and query scans.
module isms_merge_unit (
    input  logic [2:0]      i_cmd,
    input  isms_pkg::t_span i_key,
    input  isms_pkg::t_span i_cur,
    input  logic            i_placed,
    input  isms_pkg::t_span i_x,
    output isms_pkg::t_step o_step
);
    import isms_pkg::*;

    t_addr w_max_hi;

    assign w_max_hi = (i_x.hi > i_cur.hi) ? i_x.hi : i_cur.hi;

    always_comb begin
        o_step        = '0;
        o_step.cur    = i_cur;
        o_step.placed = i_placed;
        o_step.w0     = i_x;
        o_step.w1     = i_x;
        case (i_cmd)
            CMD_INSERT: begin
                if (i_placed) begin
                    o_step.w0_v = 1'b1;
                end else if (i_x.lo < i_key.lo) begin
                    // Only the predecessor can reach the new span.
                    if (i_x.hi >= i_key.lo) begin
                        o_step.cur.lo = i_x.lo;
                        o_step.cur.hi = w_max_hi;
                        o_step.merged = 1'b1;
                    end else begin
                        o_step.w0_v = 1'b1;
                    end
                end else if (i_x.lo <= i_cur.hi) begin
                    o_step.cur.hi = w_max_hi;
                    o_step.merged = 1'b1;
                end else begin
                    // The merged span goes out ahead of this entry.
                    o_step.w0_v   = 1'b1;
                    o_step.w0     = i_cur;
                    o_step.w1_v   = 1'b1;
                    o_step.placed = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (i_x.lo < i_key.lo) begin
                    o_step.w0_v = 1'b1;
                    if (i_x.hi > i_key.lo) begin
                        o_step.w0.hi = i_key.lo;
                        if (i_x.hi > i_key.hi) begin
                            // The cut lies inside this entry and splits it.
                            o_step.w1_v  = 1'b1;
                            o_step.w1.lo = i_key.hi;
                            o_step.split = 1'b1;
                        end
                    end
                end else if (i_x.lo < i_key.hi) begin
                    if (i_x.hi > i_key.hi) begin
                        o_step.w0_v  = 1'b1;
                        o_step.w0.lo = i_key.hi;
                    end
                end else begin
                    o_step.w0_v = 1'b1;
                end
            end
            CMD_QUERY: begin
                o_step.hit = (i_x.lo < i_key.hi) && (i_x.hi > i_key.lo);
            end
            default: begin
                o_step.hit = 1'b0;
            end
        endcase
    end
endmodule

@@ rtl/interval_set_merge_table.sv @@
// Interval set merge table: sorted disjoint half-open spans with insert, remove, query.
// The table keeps up to MAX_SPANS sorted, disjoint spans in one memory of two banks. Insert,
// remove and query stream the stored entries through the merge unit one per cycle, pausing
// for an entry that needs two writes; insert and remove write the new table into the other
// bank, which becomes current when the command succeeds, so a full or invalid command leaves
// the table as it was. One command is in work at a time; a finished result waits in the
// output register while the next command is accepted.
module interval_set_merge_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    isms_cmd_if.sink   i_cmd,
    isms_res_if.source o_res
);
    import isms_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_TAIL = 3'd2;
    localparam logic [2:0] S_RDW  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       r_cmd;
    t_span            r_key;
    t_span            r_cur;
    logic             r_bank;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd;
    logic [CNT_W-1:0] r_wp;
    logic             r_dv;
    logic             r_pend;
    t_span            r_w1;
    logic             r_placed;
    logic             r_merged;
    logic             r_split;
    logic             r_hit;
    logic [1:0]       r_status;
    logic             r_ov;
    logic             r_ev;
    t_span            r_entry;
    logic             r_out_valid;
    logic [1:0]       r_o_status;
    logic             r_o_ov;
    logic [CNT_W-1:0] r_o_count;
    logic             r_o_ev;
    t_span            r_o_entry;

    t_span             w_rdata;
    t_step             w_step;
    t_span             w_in;
    logic              w_accept;
    logic              w_issue;
    logic              w_we;
    t_span             w_wdata;
    logic [RAM_AW-1:0] w_raddr;
    logic [RAM_AW-1:0] w_waddr;
    logic              w_tail_wr;
    logic              w_full;
    logic [CNT_W-1:0]  w_new_count;
    logic              w_out_free;

    assign w_in.lo    = i_cmd.span_low;
    assign w_in.hi    = i_cmd.span_high;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_out_valid || o_res.ready;

    isms_merge_unit u_merge (
        .i_cmd    (r_cmd),
        .i_key    (r_key),
        .i_cur    (r_cur),
        .i_placed (r_placed),
        .i_x      (w_rdata),
        .o_step   (w_step)
    );

    // Read the next entry unless this cycle's entry needs two writes.
    assign w_issue = (r_state == S_SCAN) && (r_rd < r_count) && !(r_dv && w_step.w1_v);

    assign w_raddr = (r_state == S_SCAN) ? {r_bank, r_rd[IDX_W-1:0]}
                                         : {r_bank, i_cmd.entry_index};

    // Tail write of an insert whose span, merged or not, was not placed ahead of any entry.
    assign w_tail_wr   = (r_state == S_TAIL) && (r_cmd == CMD_INSERT) && !r_placed;
    assign w_new_count = r_wp + {{(CNT_W-1){1'b0}}, w_tail_wr};
    assign w_full      = (r_count >= CNT_W'(MAX_SPANS)) &&
                         (((r_cmd == CMD_INSERT) && !r_merged) ||
                          ((r_cmd == CMD_REMOVE) && r_split));

    // Write port selection into the other bank.
    always_comb begin
        w_we    = 1'b0;
        w_wdata = w_step.w0;
        if (r_state == S_SCAN) begin
            if (r_pend) begin
                w_we    = 1'b1;
                w_wdata = r_w1;
            end else if (r_dv && w_step.w0_v) begin
                w_we = 1'b1;
            end
        end else if (w_tail_wr) begin
            w_we    = 1'b1;
            w_wdata = r_cur;
        end
    end
    assign w_waddr = {~r_bank, r_wp[IDX_W-1:0]};

    isms_span_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Command sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bank  <= 1'b0;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_cmd.command;
                        r_key    <= w_in;
                        r_cur    <= w_in;
                        r_rd     <= '0;
                        r_wp     <= '0;
                        r_placed <= 1'b0;
                        r_merged <= 1'b0;
                        r_split  <= 1'b0;
                        r_hit    <= 1'b0;
                        r_status <= ST_OK;
                        r_ov     <= 1'b0;
                        r_ev     <= 1'b0;
                        r_entry  <= '0;
                        r_state  <= S_RESP;
                        if ((i_cmd.command == CMD_INSERT || i_cmd.command == CMD_REMOVE ||
                             i_cmd.command == CMD_QUERY) && (w_in.lo >= w_in.hi)) begin
                            r_status <= ST_INVALID;
                        end else if (i_cmd.command == CMD_INSERT ||
                                     i_cmd.command == CMD_REMOVE ||
                                     i_cmd.command == CMD_QUERY) begin
                            r_state <= S_SCAN;
                        end else if (i_cmd.command == CMD_CLEAR) begin
                            r_count <= '0;
                        end else if (i_cmd.command == CMD_READ &&
                                     {1'b0, i_cmd.entry_index} < r_count) begin
                            r_state <= S_RDW;
                        end
                    end
                end
                S_SCAN: begin
                    r_dv   <= w_issue;
                    r_pend <= 1'b0;
                    if (w_issue) begin
                        r_rd <= r_rd + CNT_W'(1);
                    end
                    if (w_we) begin
                        r_wp <= r_wp + CNT_W'(1);
                    end
                    if (r_dv) begin
                        r_cur    <= w_step.cur;
                        r_placed <= w_step.placed;
                        r_merged <= r_merged | w_step.merged;
                        r_split  <= r_split | w_step.split;
                        r_hit    <= r_hit | w_step.hit;
                        r_w1     <= w_step.w1;
                        r_pend   <= w_step.w1_v;
                    end
                    if (!r_dv && !r_pend && (r_rd == r_count)) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    r_state <= S_RESP;
                    if (r_cmd == CMD_QUERY) begin
                        r_ov <= r_hit;
                    end else if (w_full) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_bank  <= ~r_bank;
                        r_count <= w_new_count;
                    end
                end
                S_RDW: begin
                    r_ev    <= 1'b1;
                    r_entry <= w_rdata;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RESP && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESP && w_out_free) begin
            r_o_status <= r_status;
            r_o_ov     <= r_ov;
            r_o_count  <= r_count;
            r_o_ev     <= r_ev;
            r_o_entry  <= r_entry;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_o_status;
    assign o_res.overlaps    = r_o_ov;
    assign o_res.span_count  = r_o_count;
    assign o_res.entry_valid = r_o_ev;
    assign o_res.entry_low   = r_o_entry.lo;
    assign o_res.entry_high  = r_o_entry.hi;

    // The table never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPANS))
        else $error("span count above capacity");

    // A pending second write never meets fresh read data.
    a_pend_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_dv))
        else $error("second write collides with read data");

    // Read data of a scan only arrives while scanning.
    a_dv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_SCAN))
        else $error("scan data outside of scan");

    // A failed or query command leaves the bank selection alone.
    a_bank_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL && (r_cmd == CMD_QUERY || w_full)) |=> $stable(r_bank))
        else $error("bank switched on a command without effect");
endmodule

@@ bench/interval_set_merge_table_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the interval set merge table: directed table plus random commands.
module interval_set_merge_table_tb;
    import isms_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic        overlaps;
        logic [6:0]  span_count;
        logic        entry_valid;
        t_addr       entry_low;
        t_addr       entry_high;
    } t_result;

    typedef struct {
        logic [2:0] command;
        t_addr      lo;
        t_addr      hi;
        logic [5:0] idx;
        logic       has_fixed;
        t_result    fixed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    isms_cmd_if cmd_ch ();
    isms_res_if res_ch ();

    interval_set_merge_table u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    // Shadow copy of the span table.
    t_addr   shadow_lo[MAX_SPANS];
    t_addr   shadow_hi[MAX_SPANS];
    int      shadow_cnt;
    t_result pending_results[$];
    int      mismatches;
    int      cycles;
    bit      stall_long;
    bit      sending_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Find the first entry whose low is not below lo.
    function automatic int seek_entry(t_addr lo);
        int i;
        i = 0;
        while (i < shadow_cnt && shadow_lo[i] < lo) i++;
        return i;
    endfunction

    // Replace entries [s, e) by n entries, shifting the tail.
    function automatic void reshape(int s, int e, int n);
        int tail;
        t_addr tl[$];
        t_addr th[$];
        tail = shadow_cnt - e;
        for (int k = 0; k < tail; k++) begin
            tl.push_back(shadow_lo[e + k]);
            th.push_back(shadow_hi[e + k]);
        end
        for (int k = 0; k < tail; k++) begin
            shadow_lo[s + n + k] = tl[k];
            shadow_hi[s + n + k] = th[k];
        end
        shadow_cnt = s + n + tail;
    endfunction

    function automatic logic [1:0] table_insert(t_addr lo, t_addr hi);
        int i, s, e;
        i = seek_entry(lo);
        s = i;
        e = i;
        if (i > 0 && shadow_hi[i-1] >= lo) begin
            s = i - 1;
            lo = shadow_lo[s];
            if (shadow_hi[s] > hi) hi = shadow_hi[s];
        end
        while (e < shadow_cnt && shadow_lo[e] <= hi) begin
            if (shadow_hi[e] > hi) hi = shadow_hi[e];
            e++;
        end
        if (s == e && shadow_cnt >= MAX_SPANS) return ST_FULL;
        reshape(s, e, 1);
        shadow_lo[s] = lo;
        shadow_hi[s] = hi;
        return ST_OK;
    endfunction

    function automatic logic [1:0] table_remove(t_addr lo, t_addr hi);
        int i, p;
        t_addr top;
        i = seek_entry(lo);
        if (i > 0 && shadow_hi[i-1] > lo) begin
            p = i - 1;
            if (shadow_hi[p] <= hi) begin
                shadow_hi[p] = lo;
            end else begin
                top = shadow_hi[p];
                if (shadow_cnt >= MAX_SPANS) return ST_FULL;
                reshape(i, i, 1);
                shadow_hi[p] = lo;
                shadow_lo[i] = hi;
                shadow_hi[i] = top;
                return ST_OK;
            end
        end
        while (i < shadow_cnt && shadow_lo[i] < hi) begin
            if (shadow_hi[i] <= hi) begin
                reshape(i, i + 1, 0);
            end else begin
                shadow_lo[i] = hi;
                break;
            end
        end
        return ST_OK;
    endfunction

    // Work out the result of one command and update the shadow table.
    function automatic t_result predict_table(logic [2:0] c, t_addr lo, t_addr hi,
                                              logic [5:0] idx);
        t_result r;
        int i;
        r = '{ST_OK, 1'b0, 7'd0, 1'b0, '0, '0};
        if (c <= CMD_QUERY && lo >= hi) begin
            r.status = ST_INVALID;
        end else if (c == CMD_INSERT) begin
            r.status = table_insert(lo, hi);
        end else if (c == CMD_REMOVE) begin
            r.status = table_remove(lo, hi);
        end else if (c == CMD_QUERY) begin
            i = seek_entry(lo);
            r.overlaps = (i > 0 && shadow_hi[i-1] > lo) ||
                         (i < shadow_cnt && shadow_lo[i] < hi);
        end else if (c == CMD_CLEAR) begin
            shadow_cnt = 0;
        end else if (c == CMD_READ) begin
            if (idx < shadow_cnt) begin
                r.entry_valid = 1'b1;
                r.entry_low   = shadow_lo[idx];
                r.entry_high  = shadow_hi[idx];
            end
        end
        r.span_count = shadow_cnt[6:0];
        return r;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
               (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
    endfunction

    // Offer one command and wait for its transfer; valid stays up for a back-to-back one.
    task automatic send_command(logic [2:0] c, t_addr lo, t_addr hi, logic [5:0] idx,
                                bit gaps);
        int g;
        g = gaps ? short_gap() : 0;
        if (g > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= c;
        cmd_ch.span_low    <= lo;
        cmd_ch.span_high   <= hi;
        cmd_ch.entry_index <= idx;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        pending_results.push_back(predict_table(c, lo, hi, idx));
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Random span drawn from a small address window, sometimes anywhere.
    task automatic random_span(output t_addr lo, output t_addr hi);
        if ($urandom_range(0, 9) == 0) begin
            lo = t_addr'({$urandom(), $urandom()});
            hi = t_addr'({$urandom(), $urandom()});
        end else begin
            lo = t_addr'($urandom_range(0, 400));
            hi = lo + t_addr'($urandom_range(1, 30));
            if ($urandom_range(0, 19) == 0) hi = lo;
            if ($urandom_range(0, 3) == 0) begin
                lo = lo | 48'hFFFF_0000_0000;
                hi = hi | 48'hFFFF_0000_0000;
            end
        end
    endtask

    // Result side: random stalls, long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_long) begin
                res_ch.ready <= 1'b0;
                for (int k = 0; k < 300; k++) @(negedge i_clk);
                stall_long = 1'b0;
            end
            if ($urandom_range(0, 60) == 0 && !sending_done) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else begin
                res_ch.ready <= ($urandom_range(0, 3) != 0) || sending_done;
            end
        end
    end

    // Compare each transfer on the result channel with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer at %0t", $time);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status || res_ch.overlaps !== want.overlaps ||
                    res_ch.span_count !== want.span_count ||
                    res_ch.entry_valid !== want.entry_valid ||
                    res_ch.entry_low !== want.entry_low ||
                    res_ch.entry_high !== want.entry_high) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: exp st=%0d ov=%0d cnt=%0d v=%0d %h %h",
                                 $time, want.status, want.overlaps, want.span_count,
                                 want.entry_valid, want.entry_low, want.entry_high);
                        $display("    got st=%0d ov=%0d cnt=%0d v=%0d %h %h",
                                 res_ch.status, res_ch.overlaps, res_ch.span_count,
                                 res_ch.entry_valid, res_ch.entry_low, res_ch.entry_high);
                    end
                end
            end
        end
    end

    // Watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Directed table, fill-up, then random commands.
    initial begin
        t_row rows[$];
        t_row row;
        t_result fx;
        t_addr lo, hi;
        int pick;
        logic [2:0] c;
        mismatches   = 0;
        shadow_cnt   = 0;
        stall_long   = 1'b0;
        sending_done = 1'b0;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_CLEAR;
        cmd_ch.span_low = '0;
        cmd_ch.span_high = '0;
        cmd_ch.entry_index = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        fx = '{ST_OK, 1'b0, 7'd0, 1'b0, '0, '0};
        // After reset: empty read, query on empty table.
        rows.push_back('{CMD_READ, '0, '0, 6'd0, 1'b1, fx});
        rows.push_back('{CMD_QUERY, '0, '1, 6'd0, 1'b1, fx});
        // Invalid spans for each span command.
        fx.status = ST_INVALID;
        rows.push_back('{CMD_INSERT, 48'd5, 48'd5, 6'd0, 1'b1, fx});
        rows.push_back('{CMD_REMOVE, '1, '0, 6'd0, 1'b1, fx});
        rows.push_back('{CMD_QUERY, 48'd9, 48'd3, 6'd0, 1'b1, fx});
        // Extremes of the address range.
        fx = '{ST_OK, 1'b0, 7'd1, 1'b0, '0, '0};
        rows.push_back('{CMD_INSERT, '0, '1, 6'd0, 1'b1, fx});
        fx.entry_valid = 1'b1;
        fx.entry_high = '1;
        rows.push_back('{CMD_READ, '0, '0, 6'd0, 1'b1, fx});
        fx = '{ST_OK, 1'b0, 7'd1, 1'b0, '0, '0};
        rows.push_back('{CMD_READ, '0, '0, 6'd63, 1'b1, fx});
        // Split, trim, merge with the same start, delete.
        rows.push_back('{CMD_REMOVE, 48'd100, 48'd200, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_REMOVE, 48'd0, 48'd50, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_INSERT, 48'd200, 48'd300, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_INSERT, 48'd50, 48'd100, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_INSERT, 48'd50, 48'd60, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_QUERY, 48'd10, 48'd50, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_QUERY, 48'd10, 48'd51, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_REMOVE, 48'd40, 48'd120, 6'd0, 1'b0, fx});
        rows.push_back('{CMD_READ, '0, '0, 6'd1, 1'b0, fx});
        // Unknown command codes.
        rows.push_back('{3'd5, '1, '1, 6'h3F, 1'b0, fx});
        rows.push_back('{3'd7, '0, '0, 6'd0, 1'b0, fx});
        fx = '{ST_OK, 1'b0, 7'd0, 1'b0, '0, '0};
        rows.push_back('{CMD_CLEAR, '0, '0, 6'd0, 1'b1, fx});

        foreach (rows[k]) begin
            row = rows[k];
            send_command(row.command, row.lo, row.hi, row.idx, 1'b1);
            // A typed-in result must agree with the prediction just queued.
            if (row.has_fixed && pending_results[$] != row.fixed) begin
                mismatches++;
                if (mismatches <= 10) $display("directed row %0d disagrees with table", k);
            end
        end

        // Sender pauses until every result is back.
        drain_results();

        // Fill the table while the receiver holds off, then hit both full cases.
        stall_long = 1'b1;
        for (int k = 0; k < MAX_SPANS; k++)
            send_command(CMD_INSERT, t_addr'(k * 10), t_addr'(k * 10 + 5), 6'd0, 1'b0);
        send_command(CMD_INSERT, 48'd1000, 48'd1002, 6'd0, 1'b0);
        send_command(CMD_REMOVE, 48'd11, 48'd12, 6'd0, 1'b0);
        send_command(CMD_READ, '0, '0, 6'd63, 1'b0);
        send_command(CMD_QUERY, 48'd0, 48'd1, 6'd0, 1'b0);

        // Random part: mostly inserts and removes on a busy window.
        for (int n = 0; n < 700; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      c = CMD_INSERT;
            else if (pick < 65) c = CMD_REMOVE;
            else if (pick < 80) c = CMD_QUERY;
            else if (pick < 95) c = CMD_READ;
            else if (pick < 98) c = CMD_CLEAR;
            else                c = 3'($urandom_range(5, 7));
            random_span(lo, hi);
            send_command(c, lo, hi, 6'($urandom_range(0, 63)), n % 100 < 70);
        end

        sending_done = 1'b1;
        drain_results();
        repeat (100) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/isms_pkg.sv
rtl/isms_ifs.sv
rtl/isms_span_ram.sv
rtl/isms_merge_unit.sv
rtl/interval_set_merge_table.sv
bench/interval_set_merge_table_tb.sv
